// File: rtl/spr_pkg.sv
package spr_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned TypeW   = 3;
  localparam int unsigned GainW   = 32;
  localparam int unsigned OffsetW = 48;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 48;
  localparam int unsigned ExtW    = SampleW + 1;
  localparam int unsigned AccW    = 64;
  localparam int unsigned FracW   = 16;
  localparam int unsigned QW      = AccW - FracW;
  localparam int unsigned Stages  = 5;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgSampleType = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGain       = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOffset     = 2'd2;

  // sample type codes
  localparam logic [TypeW-1:0] TypeU8  = 3'd0;
  localparam logic [TypeW-1:0] TypeS8  = 3'd1;
  localparam logic [TypeW-1:0] TypeU16 = 3'd2;
  localparam logic [TypeW-1:0] TypeS16 = 3'd3;
  localparam logic [TypeW-1:0] TypeS32 = 3'd4;

  localparam logic [GainW-1:0] GainReset = 32'h0001_0000;

  typedef struct packed {
    logic [TypeW-1:0]          sample_type;
    logic signed [GainW-1:0]   gain;
    logic signed [OffsetW-1:0] offset;
  } cfg_t;

  function automatic logic signed [QW-1:0] sat_lo(input logic [TypeW-1:0] typ);
    logic signed [QW-1:0] lo;
    unique case (typ)
      TypeU8:  lo = '0;
      TypeS8:  lo = -48'sd128;
      TypeU16: lo = '0;
      TypeS16: lo = -48'sd32768;
      TypeS32: lo = -48'sd2147483648;
      default: lo = '0;
    endcase
    return lo;
  endfunction

  function automatic logic signed [QW-1:0] sat_hi(input logic [TypeW-1:0] typ);
    logic signed [QW-1:0] hi;
    unique case (typ)
      TypeU8:  hi = 48'sd255;
      TypeS8:  hi = 48'sd127;
      TypeU16: hi = 48'sd65535;
      TypeS16: hi = 48'sd32767;
      TypeS32: hi = 48'sd2147483647;
      default: hi = '0;
    endcase
    return hi;
  endfunction

endpackage

// File: rtl/spr_cfg.sv
module spr_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [spr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spr_pkg::CfgW-1:0]     cfg_data_i,
  output spr_pkg::cfg_t                cfg_o
);

  spr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_type <= spr_pkg::TypeU8;
      cfg_q.gain        <= spr_pkg::GainReset;
      cfg_q.offset      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spr_pkg::CfgSampleType: cfg_q.sample_type <= cfg_data_i[spr_pkg::TypeW-1:0];
        spr_pkg::CfgGain:       cfg_q.gain        <= cfg_data_i[spr_pkg::GainW-1:0];
        spr_pkg::CfgOffset:     cfg_q.offset      <= cfg_data_i[spr_pkg::OffsetW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/spr_mac.sv
// Stages 1-3: widen the sample, multiply by gain, add offset.
module spr_mac (
  input  logic                              clk_i,
  input  spr_pkg::cfg_t                     cfg_i,
  input  logic [2:0]                        en_i,
  input  logic [spr_pkg::SampleW-1:0]       sample_i,
  input  logic                              last_i,
  output logic signed [spr_pkg::AccW-1:0]   acc_o,
  output logic [spr_pkg::TypeW-1:0]         typ_o,
  output logic [spr_pkg::SampleW-1:0]       raw_o,
  output logic                              last_o
);

  logic signed [spr_pkg::ExtW-1:0]   ext_d, ext_q;
  logic signed [spr_pkg::AccW:0]     prod_full;
  logic signed [spr_pkg::AccW-1:0]   prod_q, acc_q;
  logic [spr_pkg::TypeW-1:0]         typ_q [3];
  logic [spr_pkg::SampleW-1:0]       raw_q [3];
  logic [2:0]                        last_q;

  always_comb begin
    unique case (cfg_i.sample_type)
      spr_pkg::TypeU8:  ext_d = {25'd0, sample_i[7:0]};
      spr_pkg::TypeS8:  ext_d = {{25{sample_i[7]}}, sample_i[7:0]};
      spr_pkg::TypeU16: ext_d = {17'd0, sample_i[15:0]};
      spr_pkg::TypeS16: ext_d = {{17{sample_i[15]}}, sample_i[15:0]};
      spr_pkg::TypeS32: ext_d = {sample_i[31], sample_i};
      default:          ext_d = '0;
    endcase
  end

  // 33x32 signed product, always fits in 64 bits
  assign prod_full = ext_q * cfg_i.gain;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ext_q     <= ext_d;
      typ_q[0]  <= cfg_i.sample_type;
      raw_q[0]  <= sample_i;
      last_q[0] <= last_i;
    end
    if (en_i[1]) begin
      prod_q    <= prod_full[spr_pkg::AccW-1:0];
      typ_q[1]  <= typ_q[0];
      raw_q[1]  <= raw_q[0];
      last_q[1] <= last_q[0];
    end
    if (en_i[2]) begin
      acc_q     <= prod_q + spr_pkg::AccW'(cfg_i.offset);
      typ_q[2]  <= typ_q[1];
      raw_q[2]  <= raw_q[1];
      last_q[2] <= last_q[1];
    end
  end

  assign acc_o  = acc_q;
  assign typ_o  = typ_q[2];
  assign raw_o  = raw_q[2];
  assign last_o = last_q[2];

endmodule

// File: rtl/spr_sat.sv
// Stages 4-5: drop the fraction toward zero, then clamp to the type range.
module spr_sat (
  input  logic                              clk_i,
  input  logic [1:0]                        en_i,
  input  logic signed [spr_pkg::AccW-1:0]   acc_i,
  input  logic [spr_pkg::TypeW-1:0]         typ_i,
  input  logic [spr_pkg::SampleW-1:0]       raw_i,
  input  logic                              last_i,
  output logic [spr_pkg::SampleW-1:0]       sample_o,
  output logic                              last_o
);

  logic signed [spr_pkg::AccW-1:0] biased;
  logic signed [spr_pkg::QW-1:0]   q_q, lo, hi;
  logic [spr_pkg::TypeW-1:0]       typ_q;
  logic [spr_pkg::SampleW-1:0]     raw_q, sample_d, sample_q;
  logic                            last_q [2];

  // negative values get 2^16-1 added so the shift rounds toward zero
  assign biased = acc_i + (acc_i[spr_pkg::AccW-1] ?
                           spr_pkg::AccW'({spr_pkg::FracW{1'b1}}) : '0);

  assign lo = spr_pkg::sat_lo(typ_q);
  assign hi = spr_pkg::sat_hi(typ_q);

  always_comb begin
    if (typ_q > spr_pkg::TypeS32) begin
      sample_d = raw_q;
    end else if (q_q < lo) begin
      sample_d = lo[spr_pkg::SampleW-1:0];
    end else if (q_q > hi) begin
      sample_d = hi[spr_pkg::SampleW-1:0];
    end else begin
      sample_d = q_q[spr_pkg::SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      q_q       <= biased[spr_pkg::AccW-1:spr_pkg::FracW];
      typ_q     <= typ_i;
      raw_q     <= raw_i;
      last_q[0] <= last_i;
    end
    if (en_i[1]) begin
      sample_q  <= sample_d;
      last_q[1] <= last_q[0];
    end
  end

  assign sample_o = sample_q;
  assign last_o   = last_q[1];

endmodule

// File: rtl/saturating_pixel_rescale_unit.sv
// Throughput: one word per cycle while out_stall_i does not hold the pipeline;
// five register stages (extend, multiply, add offset, truncate, clamp), each
// stage moves up whenever its successor frees.
// Reset: asynchronous, active low; empties the pipeline and loads sample_type u8,
// gain 1.0 and offset 0.
module saturating_pixel_rescale_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [spr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spr_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [31:0]           sample_in_i,
  input  logic                         last_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           sample_out_o,
  output logic                         last_out_o
);

  localparam int unsigned N = spr_pkg::Stages;

  spr_pkg::cfg_t                   cfg;
  logic [N-1:0]                    v_q, v_d, ready;
  logic signed [spr_pkg::AccW-1:0] acc;
  logic [spr_pkg::TypeW-1:0]       typ;
  logic [spr_pkg::SampleW-1:0]     raw, sample_out;
  logic                            last_mid;

  // a stage loads when it is empty or its contents move on this cycle
  always_comb begin
    ready[N-1] = !v_q[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      ready[k] = !v_q[k] || ready[k+1];
    end
    v_d[0] = ready[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < N; k++) begin
      v_d[k] = ready[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = v_q[N-1];

  spr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  spr_mac u_mac (
    .clk_i    (clk_i),
    .cfg_i    (cfg),
    .en_i     (ready[2:0]),
    .sample_i (sample_in_i),
    .last_i   (last_in_i),
    .acc_o    (acc),
    .typ_o    (typ),
    .raw_o    (raw),
    .last_o   (last_mid)
  );

  spr_sat u_sat (
    .clk_i    (clk_i),
    .en_i     (ready[4:3]),
    .acc_i    (acc),
    .typ_i    (typ),
    .raw_i    (raw),
    .last_i   (last_mid),
    .sample_o (sample_out),
    .last_o   (last_out_o)
  );

  assign sample_out_o = sample_out;

  // input only backs up once every stage holds a word
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  // a free output stage never blocks the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(v_q[N-1] && out_stall_i) |-> !in_stall_o)
    else $error("input stalled while output side is free");

  // a word that moves from stage 4 arrives at the output stage
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[N-2] && ready[N-1]) |=> v_q[N-1])
    else $error("word lost between truncate and clamp stages");

  // words accepted are not dropped while the output is stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted word missing from first stage");

endmodule
